FILE: hw/rtl/gbba_pkg.sv
// Package for the group bitmap block allocator.
// Holds geometry constants, status and register codes, and a bit search helper.
// No dependencies.
package gbba_pkg;

   localparam int GROUPS           = 8;
   localparam int BLOCKS_PER_GROUP = 1024;
   localparam int GROUP_BYTES      = BLOCKS_PER_GROUP / 8;
   localparam int MAP_BYTES        = GROUPS * GROUP_BYTES;
   localparam int GRP_W            = $clog2(GROUPS);
   localparam int LOC_W            = $clog2(GROUP_BYTES);
   localparam int MAP_AW           = GRP_W + LOC_W;
   localparam int OFS_W            = $clog2(BLOCKS_PER_GROUP);
   localparam int BLK_W            = 14;
   localparam int GFREE_W          = 11;
   localparam int TOTAL_FREE       = GROUPS * BLOCKS_PER_GROUP;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_WAS_FREE  = 2'd3;

   localparam logic [1:0] REG_TOTAL    = 2'd0;
   localparam logic [1:0] REG_FIRST    = 2'd1;
   localparam logic [1:0] REG_GCOUNT   = 2'd2;
   localparam logic [1:0] REG_RESERVED = 2'd3;

   localparam logic KIND_ALLOC = 1'b0;

   function automatic logic [2:0] first_zero(input logic [7:0] v);
      logic [2:0] k;
      k = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!v[i]) k = 3'(i);
      end
      return k;
   endfunction

endpackage

FILE: hw/rtl/group_bitmap_block_allocator_top.sv
// A refusal or out-of-range free goes straight to the response; a free reads and rewrites a byte.
// An allocation reduces its group modulo the group count, skips full groups, then scans one.
// One transaction at a time, rate set by the byte-per-cycle sweep of the bitmap memory read port.
// Reset is synchronous; afterwards a clearing pass over all 1024 bitmap bytes zeroes the
// memory while requests are stalled (configuration writes are still taken).
// Depends on gbba_pkg and gbba_ram.
module group_bitmap_block_allocator_top
   import gbba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [13:0]      req_pref_block,
   input  logic [2:0]       req_home_group,
   input  logic             req_privileged,
   input  logic [13:0]      req_free_block,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [13:0]      rsp_block_addr,
   output logic [13:0]      rsp_free_count,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [13:0]      csr_wdata
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MOD   = 4'd2;
   localparam logic [3:0] S_GROUP = 4'd3;
   localparam logic [3:0] S_SCAN  = 4'd4;
   localparam logic [3:0] S_PICK  = 4'd5;
   localparam logic [3:0] S_NEXT  = 4'd6;
   localparam logic [3:0] S_FRD   = 4'd7;
   localparam logic [3:0] S_FCHK  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_REHASH = 2'd1;
   localparam logic [1:0] PH_SWEEP  = 2'd2;

   localparam logic [GRP_W:0] NG_MAX = (GRP_W+1)'(GROUPS);

   logic [3:0]         state_ff, state_in;
   logic [MAP_AW-1:0]  clr_ff, clr_in;
   logic [13:0]        tblk_ff, tblk_in;
   logic               fdb_ff, fdb_in;
   logic [3:0]         gcnt_ff, gcnt_in;
   logic [13:0]        resv_ff, resv_in;
   logic [GFREE_W-1:0] gfree_ff [GROUPS];
   logic [GFREE_W-1:0] gfree_in [GROUPS];
   logic [13:0]        ftot_ff, ftot_in;
   logic               hpref_ff, hpref_in;
   logic [3:0]         pg_ff, pg_in;
   logic [OFS_W-1:0]   po_ff, po_in;
   logic [3:0]         mod_ff, mod_in;
   logic [GRP_W-1:0]   cg_ff, cg_in;
   logic [GRP_W-1:0]   icg_ff, icg_in;
   logic [GRP_W:0]     step_ff, step_in;
   logic [1:0]         phase_ff, phase_in;
   logic               pon_ff, pon_in;
   logic [LOC_W:0]     n_ff, n_in;
   logic               rdv_ff, rdv_in;
   logic               rfirst_ff, rfirst_in;
   logic [LOC_W-1:0]   rloc_ff, rloc_in;
   logic [7:0]         b0_ff, b0_in;
   logic               zf_ff, zf_in;
   logic [LOC_W-1:0]   zloc_ff, zloc_in;
   logic               nf_ff, nf_in;
   logic [LOC_W-1:0]   nloc_ff, nloc_in;
   logic [7:0]         nval_ff, nval_in;
   logic [GRP_W-1:0]   fg_ff, fg_in;
   logic [OFS_W-1:0]   fb_ff, fb_in;
   logic [1:0]         rstat_ff, rstat_in;
   logic [13:0]        raddr_ff, raddr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [13:0]        rsp_addr_ff, rsp_addr_in;
   logic [13:0]        rsp_fcnt_ff, rsp_fcnt_in;

   logic               ram_we, ram_re;
   logic [MAP_AW-1:0]  ram_waddr, ram_raddr;
   logic [7:0]         ram_wdata, ram_rdata;

   logic [GRP_W:0]     ng;
   logic [13:0]        pref_eff, pdiff, fdiff;
   logic               req_acc;
   logic [LOC_W-1:0]   start_loc, pk_loc;
   logic [2:0]         pk_k;
   logic [7:0]         pk_old;
   logic               pk_found;
   logic [GRP_W+1:0]   wsum;
   logic [GRP_W:0]     nstep;

   gbba_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_block_addr = rsp_addr_ff;
   assign rsp_free_count = rsp_fcnt_ff;
   assign req_acc        = req_valid && !req_stall;

   always_comb begin
      if (gcnt_ff == 4'd0) ng = (GRP_W+1)'(1);
      else if ({1'b0, gcnt_ff} > 5'(GROUPS)) ng = NG_MAX;
      else ng = (GRP_W+1)'(gcnt_ff);
   end

   assign pref_eff  = (req_pref_block >= tblk_ff) ? 14'd0 : req_pref_block;
   assign pdiff     = pref_eff - {13'd0, fdb_ff};
   assign fdiff     = req_free_block - {13'd0, fdb_ff};
   assign start_loc = pon_ff ? po_ff[OFS_W-1:3] : '0;

   always_comb begin
      pk_found = 1'b1;
      pk_loc   = '0;
      pk_k     = 3'd0;
      pk_old   = 8'd0;
      if (pon_ff && !b0_ff[po_ff[2:0]]) begin
         pk_loc = po_ff[OFS_W-1:3];
         pk_k   = po_ff[2:0];
         pk_old = b0_ff;
      end else if (zf_ff) begin
         pk_loc = zloc_ff;
      end else if (nf_ff) begin
         pk_loc = nloc_ff;
         pk_k   = first_zero(nval_ff);
         pk_old = nval_ff;
      end else begin
         pk_found = 1'b0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      tblk_in   = tblk_ff;
      fdb_in    = fdb_ff;
      gcnt_in   = gcnt_ff;
      resv_in   = resv_ff;
      gfree_in  = gfree_ff;
      ftot_in   = ftot_ff;
      hpref_in  = hpref_ff;
      pg_in     = pg_ff;
      po_in     = po_ff;
      mod_in    = mod_ff;
      cg_in     = cg_ff;
      icg_in    = icg_ff;
      step_in   = step_ff;
      phase_in  = phase_ff;
      pon_in    = pon_ff;
      n_in      = n_ff;
      rdv_in    = 1'b0;
      rfirst_in = 1'b0;
      rloc_in   = rloc_ff;
      b0_in     = b0_ff;
      zf_in     = zf_ff;
      zloc_in   = zloc_ff;
      nf_in     = nf_ff;
      nloc_in   = nloc_ff;
      nval_in   = nval_ff;
      fg_in     = fg_ff;
      fb_in     = fb_ff;
      rstat_in  = rstat_ff;
      raddr_in  = raddr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_fcnt_in   = rsp_fcnt_ff;
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = 8'd0;
      ram_re    = 1'b0;
      ram_raddr = {cg_ff, start_loc + n_ff[LOC_W-1:0]};
      wsum      = '0;
      nstep     = '0;

      if (csr_valid) begin
         case (csr_index)
            REG_TOTAL:    tblk_in = csr_wdata;
            REG_FIRST:    fdb_in  = csr_wdata[0];
            REG_GCOUNT:   gcnt_in = csr_wdata[3:0];
            REG_RESERVED: resv_in = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               raddr_in = 14'd0;
               rstat_in = ST_OK;
               if (req_kind == KIND_ALLOC) begin
                  if (ftot_ff == 14'd0 || (!req_privileged && ftot_ff <= resv_ff)) begin
                     rstat_in = ST_NO_SPACE;
                     state_in = S_DONE;
                  end else begin
                     hpref_in = (pref_eff != 14'd0);
                     pg_in    = (pref_eff != 14'd0) ? pdiff[13:OFS_W] : 4'd0;
                     po_in    = (pref_eff != 14'd0) ? pdiff[OFS_W-1:0] : '0;
                     mod_in   = (pref_eff != 14'd0) ? pdiff[13:OFS_W]
                                                    : {1'b0, req_home_group};
                     state_in = S_MOD;
                  end
               end else begin
                  fg_in = fdiff[OFS_W+GRP_W-1:OFS_W];
                  fb_in = fdiff[OFS_W-1:0];
                  if (req_free_block >= tblk_ff || req_free_block < {13'd0, fdb_ff} ||
                      {1'b0, fdiff[13:OFS_W]} >= {1'b0, ng}) begin
                     rstat_in = ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FRD;
                  end
               end
            end
         end
         S_MOD: begin
            if ({1'b0, mod_ff} >= {1'b0, ng}) begin
               mod_in = mod_ff - 4'(ng);
            end else begin
               cg_in    = mod_ff[GRP_W-1:0];
               icg_in   = mod_ff[GRP_W-1:0];
               phase_in = PH_FIRST;
               state_in = S_GROUP;
            end
         end
         S_GROUP: begin
            n_in  = '0;
            zf_in = 1'b0;
            nf_in = 1'b0;
            pon_in = (phase_ff == PH_FIRST) && hpref_ff && (pg_ff == 4'(cg_ff));
            if (gfree_ff[cg_ff] == '0) state_in = S_NEXT;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!n_ff[LOC_W]) begin
               ram_re    = 1'b1;
               rdv_in    = 1'b1;
               rfirst_in = (n_ff == '0);
               rloc_in   = start_loc + n_ff[LOC_W-1:0];
               n_in      = n_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (rfirst_ff) b0_in = ram_rdata;
               if (ram_rdata == 8'd0 && !zf_ff) begin
                  zf_in   = 1'b1;
                  zloc_in = rloc_ff;
               end
               if (ram_rdata != 8'hff && !nf_ff) begin
                  nf_in   = 1'b1;
                  nloc_in = rloc_ff;
                  nval_in = ram_rdata;
               end
            end else if (n_ff[LOC_W]) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (pk_found) begin
               ram_we    = 1'b1;
               ram_waddr = {cg_ff, pk_loc};
               ram_wdata = pk_old | (8'd1 << pk_k);
               ftot_in   = ftot_ff - 1'b1;
               gfree_in[cg_ff] = gfree_ff[cg_ff] - 1'b1;
               raddr_in  = 14'({1'b0, cg_ff, pk_loc, pk_k}) + {13'd0, fdb_ff};
               state_in  = S_DONE;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = S_GROUP;
            nstep    = (phase_ff == PH_FIRST) ? (GRP_W+1)'(1)
                     : (phase_ff == PH_REHASH) ? (step_ff << 1) : step_ff + 1'b1;
            if (phase_ff != PH_SWEEP && nstep < ng) begin
               wsum     = {2'b0, cg_ff} + {1'b0, nstep};
               phase_in = PH_REHASH;
               step_in  = nstep;
            end else if (phase_ff != PH_SWEEP) begin
               wsum     = {2'b0, icg_ff} + (GRP_W+2)'(2);
               phase_in = PH_SWEEP;
               step_in  = (GRP_W+1)'(2);
               if (ng <= (GRP_W+1)'(2)) begin
                  rstat_in = ST_NO_SPACE;
                  state_in = S_DONE;
               end
            end else begin
               wsum    = {2'b0, cg_ff} + (GRP_W+2)'(1);
               step_in = nstep;
               if (nstep >= ng) begin
                  rstat_in = ST_NO_SPACE;
                  state_in = S_DONE;
               end
            end
            if (wsum >= {1'b0, ng}) cg_in = GRP_W'(wsum - {1'b0, ng});
            else cg_in = wsum[GRP_W-1:0];
         end
         S_FRD: begin
            ram_re    = 1'b1;
            ram_raddr = {fg_ff, fb_ff[OFS_W-1:3]};
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            if (!ram_rdata[fb_ff[2:0]]) begin
               rstat_in = ST_WAS_FREE;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = {fg_ff, fb_ff[OFS_W-1:3]};
               ram_wdata = ram_rdata & ~(8'd1 << fb_ff[2:0]);
               ftot_in   = ftot_ff + 1'b1;
               gfree_in[fg_ff] = gfree_ff[fg_ff] + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rstat_ff;
               rsp_addr_in   = (rstat_ff == ST_OK) ? raddr_ff : 14'd0;
               rsp_fcnt_in   = ftot_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         tblk_ff      <= 14'd8193;
         fdb_ff       <= 1'b1;
         gcnt_ff      <= 4'd8;
         resv_ff      <= 14'd0;
         ftot_ff      <= 14'(TOTAL_FREE);
         for (int g = 0; g < GROUPS; g++) gfree_ff[g] <= GFREE_W'(BLOCKS_PER_GROUP);
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         rfirst_ff    <= 1'b0;
         zf_ff        <= 1'b0;
         nf_ff        <= 1'b0;
         phase_ff     <= PH_FIRST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tblk_ff      <= tblk_in;
         fdb_ff       <= fdb_in;
         gcnt_ff      <= gcnt_in;
         resv_ff      <= resv_in;
         ftot_ff      <= ftot_in;
         gfree_ff     <= gfree_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         rfirst_ff    <= rfirst_in;
         zf_ff        <= zf_in;
         nf_ff        <= nf_in;
         phase_ff     <= phase_in;
      end
      hpref_ff      <= hpref_in;
      pg_ff         <= pg_in;
      po_ff         <= po_in;
      mod_ff        <= mod_in;
      cg_ff         <= cg_in;
      icg_ff        <= icg_in;
      step_ff       <= step_in;
      pon_ff        <= pon_in;
      n_ff          <= n_in;
      rloc_ff       <= rloc_in;
      b0_ff         <= b0_in;
      zloc_ff       <= zloc_in;
      nloc_ff       <= nloc_in;
      nval_ff       <= nval_in;
      fg_ff         <= fg_in;
      fb_ff         <= fb_in;
      rstat_ff      <= rstat_in;
      raddr_ff      <= raddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_fcnt_ff   <= rsp_fcnt_in;
   end

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      ftot_ff <= 14'(TOTAL_FREE))
      else $error("free total above capacity");
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");
   a_scan_nonfull: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (gfree_ff[cg_ff] != '0))
      else $error("scanning a group with no free blocks");
`endif
endmodule

FILE: hw/rtl/gbba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata <= mem[raddr];
   end
endmodule
